### rtl/core/tbo_pkg.sv
package tbo_pkg;

   localparam int TOKEN_BITS_DEFAULT = 48;
   localparam int TIME_BITS_DEFAULT  = 48;
   localparam int FRAC_BITS          = 16;
   localparam int CSR_ADDR_BITS      = 2;

   typedef struct packed {
      logic start;
      logic is_div;
   } mdu_ctl_type;

endpackage

### rtl/core/tbo_mdu.sv
module tbo_mdu #(
   parameter int TOKEN_BITS = tbo_pkg::TOKEN_BITS_DEFAULT,
   parameter int TIME_BITS  = tbo_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tbo_pkg::mdu_ctl_type                      ctl,
   input  logic [TOKEN_BITS-1:0]                     opd_rate,
   input  logic [TIME_BITS-1:0]                      opd_time,
   input  logic [TOKEN_BITS+tbo_pkg::FRAC_BITS-1:0]  opd_dividend,
   output logic                                      done,
   output logic [TOKEN_BITS+TIME_BITS-1:0]           product,
   output logic [TOKEN_BITS+tbo_pkg::FRAC_BITS-1:0]  quotient
);
   import tbo_pkg::*;

   localparam int QW = TOKEN_BITS + FRAC_BITS;
   localparam int SW = (QW > TIME_BITS) ? QW : TIME_BITS;
   localparam int CW = $clog2(SW + 1);
   localparam int AW = TOKEN_BITS + 2;

   logic                  busy_ff, busy_in;
   logic                  div_ff, div_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [TOKEN_BITS-1:0] acc_ff, acc_in;
   logic [SW-1:0]         sh_ff, sh_in;
   logic [TOKEN_BITS:0]   x, y;
   logic [AW-1:0]         res;

   // one adder serves both: add for shift-add multiply, subtract for restoring divide
   always_comb begin
      if (div_ff) begin
         x = {acc_ff, sh_ff[QW-1]};
         y = {1'b0, opd_rate};
      end else begin
         x = {1'b0, acc_ff};
         y = sh_ff[0] ? {1'b0, opd_rate} : '0;
      end
      res = {1'b0, x} + ({1'b0, y} ^ {AW{div_ff}}) + AW'(div_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.is_div;
         acc_in  = '0;
         sh_in   = ctl.is_div ? SW'(opd_dividend) : SW'(opd_time);
         cnt_in  = ctl.is_div ? CW'(QW) : CW'(TIME_BITS);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (div_ff) begin
            acc_in = res[AW-1] ? x[TOKEN_BITS-1:0] : res[TOKEN_BITS-1:0];
            sh_in  = SW'({sh_ff[QW-2:0], ~res[AW-1]});
         end else begin
            acc_in = res[TOKEN_BITS:1];
            sh_in  = SW'({res[0], sh_ff[TIME_BITS-1:1]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
   end

   assign done     = done_ff;
   assign product  = {acc_ff, sh_ff[TIME_BITS-1:0]};
   assign quotient = sh_ff[QW-1:0];

endmodule

### rtl/core/token_bucket_with_overflow.sv
// Token bucket with variable refill rate and spill reporting for a downstream store.
// Input channel req_*: one item per command (query, add/remove tokens, add/remove
// rate, restart) with an amount and the current tick. Result channel rsp_*: exactly
// one item per input item, carrying the token level, the predicted fill tick for a
// query, spilled tokens, the rate change to forward and a status code.
// Configuration goes through csr_we/csr_addr/csr_wdata, one register per write;
// the user is to write it only while the block is idle, the block itself does not enforce this.
// A query runs the refill multiply, one multiplier bit per cycle, and, when the bucket
// is below a nonzero cap and the rate is nonzero, the fill-time divide, one quotient
// bit per cycle, both on the shared multiply/divide unit; other commands use only
// the short add/subtract steps.
// One item is worked on at a time; req_ready is high only between items.
// The result sits in an output register, so a new item is accepted while the
// previous result waits; if rsp_ready stays low, the next result is held back
// in the last step until the output register frees up.
// Reset clears the bucket state and all configuration registers to zero.
module token_bucket_with_overflow #(
   parameter int TOKEN_BITS = tbo_pkg::TOKEN_BITS_DEFAULT,
   parameter int TIME_BITS  = tbo_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_cmd,
   input  logic [TOKEN_BITS-1:0]             req_amount,
   input  logic [TIME_BITS-1:0]              req_now_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [TOKEN_BITS-1:0]             rsp_token_count,
   output logic [TIME_BITS-1:0]              rsp_overflow_time,
   output logic                              rsp_overflow_valid,
   output logic [TOKEN_BITS-1:0]             rsp_excess_tokens,
   output logic signed [TOKEN_BITS:0]        rsp_excess_rate_delta,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_we,
   input  logic [tbo_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [TOKEN_BITS-1:0]             csr_wdata
);
   import tbo_pkg::*;

   localparam int N   = TOKEN_BITS;
   localparam int T   = TIME_BITS;
   localparam int DW  = (N > T) ? N : T;
   localparam int QW  = N + FRAC_BITS;
   localparam int OW  = ((QW > T) ? QW : T) + 1;

   localparam logic [2:0] CMD_QUERY    = 3'd0;
   localparam logic [2:0] CMD_ADD_TOK  = 3'd1;
   localparam logic [2:0] CMD_RM_TOK   = 3'd2;
   localparam logic [2:0] CMD_ADD_RATE = 3'd3;
   localparam logic [2:0] CMD_RM_RATE  = 3'd4;
   localparam logic [2:0] CMD_RESTART  = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_TOKENS = 2'd1;
   localparam logic [1:0] STATUS_RATE_UF   = 2'd2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_TOKENS   = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_TOKENS = CSR_ADDR_BITS'(1);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_RATE   = CSR_ADDR_BITS'(2);
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXCESS_EN    = CSR_ADDR_BITS'(3);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ELAPSED,
      S_MUL_WAIT,
      S_ADD_SUM,
      S_ADD_CLAMP,
      S_ADD_DELTA,
      S_OVF_CHECK,
      S_DIV_WAIT,
      S_RMTOK,
      S_ADDRATE_FWD,
      S_ADDRATE,
      S_RMRATE,
      S_RMRATE_FWD,
      S_FINISH
   } state_type;

   state_type     state_ff;

   logic [N-1:0]  max_ff, start_tok_ff, start_rate_ff;
   logic          exc_en_ff;
   logic [N-1:0]  level_ff, rate_ff, fwd_ff;
   logic [T-1:0]  last_ff;

   logic [T-1:0]  now_ff;
   logic [N-1:0]  amount_ff, add_ff, sum_ff;
   logic          full_ff, qry_ff;
   logic [N-1:0]  exc_ff;
   logic [N:0]    delta_ff;
   logic [T-1:0]  otime_ff;
   logic          ovalid_ff;
   logic [1:0]    status_ff;

   logic          rsp_valid_ff;
   logic [N-1:0]  rsp_token_ff, rsp_exc_ff;
   logic [T-1:0]  rsp_otime_ff;
   logic          rsp_ovalid_ff;
   logic [N:0]    rsp_delta_ff;
   logic [1:0]    rsp_status_ff;

   logic [DW-1:0] opa, opb;
   logic          op_sub;
   logic [DW:0]   alu;
   logic          borrow, carry;

   mdu_ctl_type   mdu_ctl;
   logic          mdu_done;
   logic [N+T-1:0] mdu_product;
   logic [QW-1:0] mdu_quotient;
   logic [T-1:0]  elapsed;
   logic [QW-1:0] dividend;
   logic [N-1:0]  refill;
   logic          ovf_go, spill_fwd;
   logic          q_late;
   logic [OW-1:0] otime_sum;
   state_type     after_add;

   // shared add/subtract for the short steps
   always_comb begin
      opa    = '0;
      opb    = '0;
      op_sub = 1'b0;
      case (state_ff)
         S_ELAPSED: begin
            opa = DW'(now_ff);   opb = DW'(last_ff);   op_sub = 1'b1;
         end
         S_ADD_SUM: begin
            opa = DW'(level_ff); opb = DW'(add_ff);
         end
         S_ADD_CLAMP: begin
            opa = DW'(sum_ff);   opb = DW'(max_ff);    op_sub = 1'b1;
         end
         S_ADD_DELTA: begin
            opa = DW'(rate_ff);  opb = DW'(fwd_ff);    op_sub = 1'b1;
         end
         S_OVF_CHECK: begin
            opa = DW'(max_ff);   opb = DW'(level_ff);  op_sub = 1'b1;
         end
         S_RMTOK: begin
            opa = DW'(level_ff); opb = DW'(amount_ff); op_sub = 1'b1;
         end
         S_ADDRATE_FWD: begin
            opa = DW'(fwd_ff);   opb = DW'(amount_ff);
         end
         S_ADDRATE: begin
            opa = DW'(rate_ff);  opb = DW'(amount_ff);
         end
         S_RMRATE: begin
            opa = DW'(rate_ff);  opb = DW'(amount_ff); op_sub = 1'b1;
         end
         S_RMRATE_FWD: begin
            opa = DW'(fwd_ff);   opb = DW'(amount_ff); op_sub = 1'b1;
         end
         default: begin
            opa = '0;
         end
      endcase
      alu    = {1'b0, opa} + ({1'b0, opb} ^ {(DW + 1){op_sub}}) + (DW + 1)'(op_sub);
      borrow = alu[DW];
      carry  = alu[N];
   end

   always_comb begin
      elapsed   = borrow ? '0 : alu[T-1:0];
      dividend  = {alu[N-1:0], {FRAC_BITS{1'b0}}};
      ovf_go    = (max_ff != '0) && !borrow && (alu[N-1:0] != '0) && (rate_ff != '0);
      refill    = ((mdu_product >> (N + FRAC_BITS)) != '0) ? '1
                                                           : mdu_product[N+FRAC_BITS-1:FRAC_BITS];
      q_late    = OW'(mdu_quotient) >= {{(OW - T){1'b0}}, ~now_ff};
      otime_sum = OW'(now_ff) + OW'(mdu_quotient) + OW'(1);
      spill_fwd = full_ff && exc_en_ff;
      after_add = qry_ff ? S_OVF_CHECK : S_FINISH;
      mdu_ctl.start  = (state_ff == S_ELAPSED) || ((state_ff == S_OVF_CHECK) && ovf_go);
      mdu_ctl.is_div = (state_ff == S_OVF_CHECK);
   end

   tbo_mdu #(
      .TOKEN_BITS (TOKEN_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_mdu (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mdu_ctl),
      .opd_rate     (rate_ff),
      .opd_time     (elapsed),
      .opd_dividend (dividend),
      .done         (mdu_done),
      .product      (mdu_product),
      .quotient     (mdu_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_ff        <= '0;
         start_tok_ff  <= '0;
         start_rate_ff <= '0;
         exc_en_ff     <= 1'b0;
         level_ff      <= '0;
         rate_ff       <= '0;
         fwd_ff        <= '0;
         last_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MAX_TOKENS:   max_ff        <= csr_wdata;
               CSR_START_TOKENS: start_tok_ff  <= csr_wdata;
               CSR_START_RATE:   start_rate_ff <= csr_wdata;
               CSR_EXCESS_EN:    exc_en_ff     <= csr_wdata[0];
               default:          exc_en_ff     <= exc_en_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  now_ff    <= req_now_time;
                  amount_ff <= req_amount;
                  full_ff   <= (max_ff != '0) && (level_ff == max_ff);
                  qry_ff    <= (req_cmd == CMD_QUERY);
                  exc_ff    <= '0;
                  delta_ff  <= '0;
                  otime_ff  <= '0;
                  ovalid_ff <= 1'b0;
                  status_ff <= STATUS_OK;
                  case (req_cmd)
                     CMD_QUERY: begin
                        state_ff <= S_ELAPSED;
                     end
                     CMD_ADD_TOK: begin
                        add_ff   <= req_amount;
                        state_ff <= S_ADD_SUM;
                     end
                     CMD_RM_TOK: begin
                        state_ff <= (req_amount == '0) ? S_FINISH : S_RMTOK;
                     end
                     CMD_ADD_RATE: begin
                        state_ff <= (req_amount == '0) ? S_FINISH : S_ADDRATE_FWD;
                     end
                     CMD_RM_RATE: begin
                        state_ff <= (req_amount == '0) ? S_FINISH : S_RMRATE;
                     end
                     CMD_RESTART: begin
                        level_ff <= '0;
                        rate_ff  <= start_rate_ff;
                        fwd_ff   <= '0;
                        last_ff  <= req_now_time;
                        add_ff   <= start_tok_ff;
                        state_ff <= S_ADD_SUM;
                     end
                     default: begin
                        state_ff <= S_FINISH;
                     end
                  endcase
               end
            end
            S_ELAPSED: begin
               last_ff  <= now_ff;
               state_ff <= S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
               if (mdu_done) begin
                  add_ff   <= refill;
                  state_ff <= S_ADD_SUM;
               end
            end
            S_ADD_SUM: begin
               if (add_ff == '0) begin
                  state_ff <= after_add;
               end else begin
                  sum_ff   <= carry ? '1 : alu[N-1:0];
                  state_ff <= S_ADD_CLAMP;
               end
            end
            S_ADD_CLAMP: begin
               if ((max_ff != '0) && !borrow) begin
                  level_ff <= max_ff;
                  if (exc_en_ff) begin
                     exc_ff   <= alu[N-1:0];
                     state_ff <= S_ADD_DELTA;
                  end else begin
                     state_ff <= after_add;
                  end
               end else begin
                  level_ff <= sum_ff;
                  state_ff <= after_add;
               end
            end
            S_ADD_DELTA: begin
               delta_ff <= alu[N:0];
               fwd_ff   <= rate_ff;
               state_ff <= after_add;
            end
            S_OVF_CHECK: begin
               state_ff <= ovf_go ? S_DIV_WAIT : S_FINISH;
            end
            S_DIV_WAIT: begin
               if (mdu_done) begin
                  otime_ff  <= q_late ? '1 : otime_sum[T-1:0];
                  ovalid_ff <= 1'b1;
                  state_ff  <= S_FINISH;
               end
            end
            S_RMTOK: begin
               if (borrow) begin
                  status_ff <= STATUS_NO_TOKENS;
               end else begin
                  level_ff <= alu[N-1:0];
                  if (spill_fwd) begin
                     delta_ff <= (N + 1)'(0) - {1'b0, fwd_ff};
                     fwd_ff   <= '0;
                  end
               end
               state_ff <= S_FINISH;
            end
            S_ADDRATE_FWD: begin
               if (spill_fwd) begin
                  delta_ff <= {1'b0, amount_ff};
                  fwd_ff   <= carry ? '1 : alu[N-1:0];
               end
               state_ff <= S_ADDRATE;
            end
            S_ADDRATE: begin
               rate_ff  <= carry ? '1 : alu[N-1:0];
               state_ff <= S_FINISH;
            end
            S_RMRATE: begin
               if (borrow) begin
                  status_ff <= STATUS_RATE_UF;
                  state_ff  <= S_FINISH;
               end else begin
                  rate_ff <= alu[N-1:0];
                  if (spill_fwd) begin
                     delta_ff <= (N + 1)'(0) - {1'b0, amount_ff};
                     state_ff <= S_RMRATE_FWD;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_RMRATE_FWD: begin
               fwd_ff   <= borrow ? '0 : alu[N-1:0];
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_token_ff  <= level_ff;
                  rsp_otime_ff  <= otime_ff;
                  rsp_ovalid_ff <= ovalid_ff;
                  rsp_exc_ff    <= exc_ff;
                  rsp_delta_ff  <= delta_ff;
                  rsp_status_ff <= status_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_token_count       = rsp_token_ff;
   assign rsp_overflow_time     = rsp_otime_ff;
   assign rsp_overflow_valid    = rsp_ovalid_ff;
   assign rsp_excess_tokens     = rsp_exc_ff;
   assign rsp_excess_rate_delta = $signed(rsp_delta_ff);
   assign rsp_status            = rsp_status_ff;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam logic [47:0] TOK_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] TIM_MAX = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] CMD_QUERY         = 3'd0;
   localparam logic [2:0] CMD_ADD_TOKENS    = 3'd1;
   localparam logic [2:0] CMD_REMOVE_TOKENS = 3'd2;
   localparam logic [2:0] CMD_ADD_RATE      = 3'd3;
   localparam logic [2:0] CMD_REMOVE_RATE   = 3'd4;
   localparam logic [2:0] CMD_RESTART       = 3'd5;
   localparam logic [2:0] CMD_UNUSED_6      = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7      = 3'd7;

   localparam logic [1:0] ST_OK             = 2'd0;
   localparam logic [1:0] ST_SHORT_TOKENS   = 2'd1;
   localparam logic [1:0] ST_RATE_UNDERFLOW = 2'd2;

   localparam logic [tbo_pkg::CSR_ADDR_BITS-1:0] REG_MAX_TOKENS     = 0;
   localparam logic [tbo_pkg::CSR_ADDR_BITS-1:0] REG_START_TOKENS   = 1;
   localparam logic [tbo_pkg::CSR_ADDR_BITS-1:0] REG_START_RATE     = 2;
   localparam logic [tbo_pkg::CSR_ADDR_BITS-1:0] REG_EXCESS_ENABLED = 3;

   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 260;

   typedef struct packed {
      logic [47:0] level;
      logic [47:0] otime;
      logic        ovalid;
      logic [47:0] exc;
      logic [48:0] delta;
      logic [1:0]  status;
   } bucket_result_type;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum int {RX_ALWAYS, RX_COIN, RX_COMB, RX_LONG} rx_mode_type;

   // csr rows carry the register index in code and the write data in amount
   typedef struct {
      row_kind_type kind;
      logic [2:0]  code;
      logic [47:0] amount;
      logic [47:0] now;
      bit          typed;
      logic [47:0] exp_level;
      logic [1:0]  exp_status;
   } dir_row_type;

   dir_row_type dir_rows [31] = '{
      '{ROW_ITEM, CMD_QUERY,         48'h0,            48'h0,            1, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_REMOVE_TOKENS, 48'h1,            48'h0,            1, 48'h0,
        ST_SHORT_TOKENS},
      '{ROW_ITEM, CMD_REMOVE_RATE,   48'h1,            48'h0,            1, 48'h0,
        ST_RATE_UNDERFLOW},
      '{ROW_ITEM, CMD_ADD_TOKENS,    TOK_MAX,          48'h0,            1, TOK_MAX, ST_OK},
      '{ROW_ITEM, CMD_REMOVE_TOKENS, TOK_MAX,          48'h0,            1, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_ADD_RATE,      TOK_MAX,          48'h0,            1, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_ADD_RATE,      48'h1,            48'h0,            1, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_QUERY,         48'h0,            TIM_MAX,          1, TOK_MAX, ST_OK},
      '{ROW_ITEM, CMD_REMOVE_RATE,   TOK_MAX,          48'h0,            1, TOK_MAX, ST_OK},
      '{ROW_ITEM, CMD_UNUSED_7,      TOK_MAX,          TIM_MAX,          1, TOK_MAX, ST_OK},
      '{ROW_ITEM, CMD_ADD_TOKENS,    48'h0,            48'h0,            1, TOK_MAX, ST_OK},
      '{ROW_ITEM, CMD_RESTART,       48'h0,            48'd100,          1, 48'h0,   ST_OK},
      '{ROW_CSR,  3'(REG_MAX_TOKENS),    48'h3E8_0000,    48'h0,         0, 48'h0,   ST_OK},
      '{ROW_CSR,  3'(REG_START_TOKENS),  48'h258_0000,    48'h0,         0, 48'h0,   ST_OK},
      '{ROW_CSR,  3'(REG_START_RATE),    48'h1_0000_0000, 48'h0,         0, 48'h0,   ST_OK},
      '{ROW_CSR,  3'(REG_EXCESS_ENABLED), 48'h1,          48'h0,         0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_RESTART,       48'h0,            48'h0,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_QUERY,         48'h0,            48'd10,           0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_QUERY,         48'h0,            48'd2000,         0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_ADD_RATE,      48'h8000_0000,    48'h0,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_REMOVE_TOKENS, 48'h64_0000,      48'h0,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_ADD_TOKENS,    TOK_MAX,          48'h0,            0, 48'h0,   ST_OK},
      '{ROW_CSR,  3'(REG_EXCESS_ENABLED), 48'h0,          48'h0,         0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_ADD_TOKENS,    48'h2_0000,       48'h0,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_ADD_RATE,      48'h4_0000_0000,  48'h0,            0, 48'h0,   ST_OK},
      '{ROW_CSR,  3'(REG_EXCESS_ENABLED), 48'h1,          48'h0,         0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_REMOVE_RATE,   48'h2_0000_0000,  48'h0,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_QUERY,         48'h0,            48'd1,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_RESTART,       48'h0,            48'hFFFF_FFFF_FFF5, 0, 48'h0, ST_OK},
      '{ROW_ITEM, CMD_REMOVE_RATE,   48'hFFFF_FFFF,    48'h0,            0, 48'h0,   ST_OK},
      '{ROW_ITEM, CMD_QUERY,         48'h0,            48'hFFFF_FFFF_FFFA, 0, 48'h0, ST_OK}
   };

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [2:0]                          req_cmd;
   logic [47:0]                         req_amount;
   logic [47:0]                         req_now_time;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [47:0]                         rsp_token_count;
   logic [47:0]                         rsp_overflow_time;
   logic                                rsp_overflow_valid;
   logic [47:0]                         rsp_excess_tokens;
   logic signed [48:0]                  rsp_excess_rate_delta;
   logic [1:0]                          rsp_status;
   logic                                csr_we;
   logic [tbo_pkg::CSR_ADDR_BITS-1:0]   csr_addr;
   logic [47:0]                         csr_wdata;

   token_bucket_with_overflow dut (.*);

   // bucket predictor state and configuration
   logic [47:0] bkt_level, bkt_rate, bkt_fwd_rate, bkt_last_time;
   logic [47:0] cap_tokens, restart_tokens, restart_rate;
   bit          spill_on;
   bucket_result_type predicted;

   bucket_result_type pending_results [$];
   bucket_result_type want_result;
   int          mismatch_count;
   int          results_seen;
   logic [47:0] timeline;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(64'd40_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? TOK_MAX : s[47:0];
   endfunction

   function automatic bit bucket_full();
      return cap_tokens != 0 && bkt_level == cap_tokens;
   endfunction

   function automatic void pour_tokens(input logic [47:0] add);
      logic [47:0] sum;
      if (add == 0) return;
      sum = sat_sum(bkt_level, add);
      if (cap_tokens != 0 && sum >= cap_tokens) begin
         if (spill_on) begin
            predicted.exc = sum - cap_tokens;
            predicted.delta = {1'b0, bkt_rate} - {1'b0, bkt_fwd_rate};
            bkt_fwd_rate = bkt_rate;
         end
         bkt_level = cap_tokens;
      end else begin
         bkt_level = sum;
      end
   endfunction

   function automatic void predict_bucket(input logic [2:0] cmd, input logic [47:0] amount,
                                          input logic [47:0] now);
      logic [47:0] elapsed;
      logic [47:0] refill;
      logic [47:0] deficit;
      logic [95:0] product;
      logic [63:0] quotient;
      predicted = '0;
      case (cmd)
         CMD_QUERY: begin
            elapsed = (now >= bkt_last_time) ? now - bkt_last_time : 48'h0;
            product = {48'h0, bkt_rate} * {48'h0, elapsed};
            refill = (|product[95:64]) ? TOK_MAX : product[63:16];
            pour_tokens(refill);
            bkt_last_time = now;
            if (cap_tokens != 0 && bkt_level < cap_tokens && bkt_rate != 0) begin
               deficit = cap_tokens - bkt_level;
               quotient = {deficit, 16'h0} / {16'h0, bkt_rate};
               predicted.otime = (quotient >= {16'h0, TIM_MAX - now}) ? TIM_MAX
                                 : now + quotient[47:0] + 48'd1;
               predicted.ovalid = 1'b1;
            end
         end
         CMD_ADD_TOKENS: begin
            pour_tokens(amount);
         end
         CMD_REMOVE_TOKENS: begin
            if (amount != 0) begin
               if (bkt_level < amount) begin
                  predicted.status = ST_SHORT_TOKENS;
               end else begin
                  if (bucket_full() && spill_on) begin
                     predicted.delta = 49'h0 - {1'b0, bkt_fwd_rate};
                     bkt_fwd_rate = '0;
                  end
                  bkt_level = bkt_level - amount;
               end
            end
         end
         CMD_ADD_RATE: begin
            if (amount != 0) begin
               if (bucket_full() && spill_on) begin
                  predicted.delta = {1'b0, amount};
                  bkt_fwd_rate = sat_sum(bkt_fwd_rate, amount);
               end
               bkt_rate = sat_sum(bkt_rate, amount);
            end
         end
         CMD_REMOVE_RATE: begin
            if (amount != 0) begin
               if (amount > bkt_rate) begin
                  predicted.status = ST_RATE_UNDERFLOW;
               end else begin
                  if (bucket_full() && spill_on) begin
                     predicted.delta = 49'h0 - {1'b0, amount};
                     bkt_fwd_rate = (bkt_fwd_rate >= amount) ? bkt_fwd_rate - amount : 48'h0;
                  end
                  bkt_rate = bkt_rate - amount;
               end
            end
         end
         CMD_RESTART: begin
            bkt_level = '0;
            bkt_rate = restart_rate;
            bkt_fwd_rate = '0;
            bkt_last_time = now;
            pour_tokens(restart_tokens);
         end
         default: ;
      endcase
      predicted.level = bkt_level;
   endfunction

   function automatic logic [47:0] pick_tokens();
      case ($urandom_range(0, 9))
         0: return 48'h0;
         1: return TOK_MAX;
         2: return bkt_level;
         3: return sat_sum(bkt_level, 48'h1);
         4: return cap_tokens - bkt_level;
         5: return rand48() >> $urandom_range(0, 47);
         default: return rand48() >> $urandom_range(16, 47);
      endcase
   endfunction

   function automatic logic [47:0] pick_rate();
      case ($urandom_range(0, 9))
         0: return 48'h0;
         1: return TOK_MAX;
         2: return bkt_rate;
         3: return sat_sum(bkt_rate, 48'h1);
         4: return bkt_fwd_rate;
         5: return rand48();
         default: return rand48() >> $urandom_range(12, 40);
      endcase
   endfunction

   function automatic logic [47:0] advance_clock();
      logic [48:0] t;
      case ($urandom_range(0, 19))
         0: timeline = rand48();
         1: timeline = TIM_MAX - $urandom_range(0, 200);
         2: timeline = timeline - $urandom_range(0, 100);
         3: begin
            t = {1'b0, timeline} + {1'b0, rand48() >> $urandom_range(8, 47)};
            timeline = t[48] ? TIM_MAX : t[47:0];
         end
         default: begin
            t = {1'b0, timeline} + $urandom_range(0, 64);
            timeline = t[48] ? TIM_MAX : t[47:0];
         end
      endcase
      return timeline;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: result %0d %s mismatch, expected %h, got %h",
                     $time, results_seen, name, want, got);
      end
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_item(input logic [2:0] cmd, input logic [47:0] amount,
                            input logic [47:0] now, input bit typed,
                            input logic [47:0] typed_level, input logic [1:0] typed_status);
      bucket_result_type r;
      req_cmd = cmd;
      req_amount = amount;
      req_now_time = now;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_bucket(cmd, amount, now);
      r = predicted;
      if (typed) begin
         r = '0;
         r.level = typed_level;
         r.status = typed_status;
      end
      pending_results.push_back(r);
      @(negedge clock);
   endtask

   task automatic settle_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [tbo_pkg::CSR_ADDR_BITS-1:0] idx,
                            input logic [47:0] value);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      case (idx)
         REG_MAX_TOKENS:     cap_tokens = value;
         REG_START_TOKENS:   restart_tokens = value;
         REG_START_RATE:     restart_rate = value;
         REG_EXCESS_ENABLED: spill_on = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result item with nothing pending, token_count %h",
                        $time, rsp_token_count);
         end else begin
            want_result = pending_results.pop_front();
            check_field("token_count", 64'(want_result.level), 64'(rsp_token_count));
            check_field("overflow_time", 64'(want_result.otime), 64'(rsp_overflow_time));
            check_field("overflow_valid", 64'(want_result.ovalid), 64'(rsp_overflow_valid));
            check_field("excess_tokens", 64'(want_result.exc), 64'(rsp_excess_tokens));
            check_field("excess_rate_delta", 64'(want_result.delta),
                        64'($unsigned(rsp_excess_rate_delta)));
            check_field("status", 64'(want_result.status), 64'(rsp_status));
         end
         results_seen++;
      end
   end

   // receiver stall patterns
   initial begin
      rx_mode_type rx_mode;
      int       rx_left;
      int       rx_hold;
      rsp_ready = 1'b0;
      rx_mode = RX_ALWAYS;
      rx_left = 0;
      rx_hold = 0;
      forever begin
         @(negedge clock);
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 400);
         end
         rx_left--;
         case (rx_mode)
            RX_ALWAYS: rsp_ready = 1'b1;
            RX_COIN:   rsp_ready = 1'($urandom_range(0, 1));
            RX_COMB:   rsp_ready = (rx_left % 4) != 0;
            default: begin
               if (rx_hold == 0) begin
                  rsp_ready = !rsp_ready;
                  rx_hold = rsp_ready ? $urandom_range(1, 6) : $urandom_range(4, 40);
               end else begin
                  rx_hold--;
               end
            end
         endcase
      end
   end

   initial begin
      int          burst_left;
      int          gap;
      int          sel;
      logic [2:0]  cmd;
      logic [47:0] amount;
      logic [47:0] word;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_QUERY;
      req_amount = '0;
      req_now_time = '0;
      csr_we = 1'b0;
      csr_addr = REG_MAX_TOKENS;
      csr_wdata = '0;
      bkt_level = '0;
      bkt_rate = '0;
      bkt_fwd_rate = '0;
      bkt_last_time = '0;
      cap_tokens = '0;
      restart_tokens = '0;
      restart_rate = '0;
      spill_on = 1'b0;
      mismatch_count = 0;
      results_seen = 0;
      timeline = '0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            settle_idle();
            write_csr(dir_rows[i].code[1:0], dir_rows[i].amount);
         end else begin
            push_item(dir_rows[i].code, dir_rows[i].amount, dir_rows[i].now,
                      dir_rows[i].typed, dir_rows[i].exp_level, dir_rows[i].exp_status);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_idle();
         case (p)
            0: word = '0;
            1: word = TOK_MAX;
            default: word = rand48() >> $urandom_range(4, 36);
         endcase
         write_csr(REG_MAX_TOKENS, word);
         case (p)
            2: word = TOK_MAX;
            3: word = '0;
            default: word = rand48() >> $urandom_range(4, 40);
         endcase
         write_csr(REG_START_TOKENS, word);
         case (p)
            4: word = TOK_MAX;
            5: word = '0;
            default: word = rand48() >> $urandom_range(12, 36);
         endcase
         write_csr(REG_START_RATE, word);
         word = '0;
         if (p >= 6) word = rand48();
         word[0] = p[0];
         write_csr(REG_EXCESS_ENABLED, word);
         push_item(CMD_RESTART, rand48(), advance_clock(), 1'b0, '0, ST_OK);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) == 0) settle_idle();
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               if (gap != 0) begin
                  req_valid = 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            sel = $urandom_range(0, 99);
            if (sel < 30) cmd = CMD_QUERY;
            else if (sel < 46) cmd = CMD_ADD_TOKENS;
            else if (sel < 62) cmd = CMD_REMOVE_TOKENS;
            else if (sel < 74) cmd = CMD_ADD_RATE;
            else if (sel < 86) cmd = CMD_REMOVE_RATE;
            else if (sel < 95) cmd = CMD_RESTART;
            else cmd = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
            case (cmd)
               CMD_ADD_TOKENS, CMD_REMOVE_TOKENS: amount = pick_tokens();
               CMD_ADD_RATE, CMD_REMOVE_RATE:     amount = pick_rate();
               default:                           amount = rand48();
            endcase
            push_item(cmd, amount, advance_clock(), 1'b0, '0, ST_OK);
         end
      end

      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
